>>> rtl/kvps_pkg.sv
// Shared constants, types and command codes of the KV page selector.
package kvps_pkg;

  localparam int LAYERS       = 32;
  localparam int KV_HEADS_MAX = 8;
  localparam int MAX_PAGES    = 64;
  localparam int HEAD_DIM_MAX = 128;

  localparam int ROWS     = LAYERS * KV_HEADS_MAX;
  localparam int ROW_W    = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int PG_W     = $clog2(MAX_PAGES);
  localparam int NP_W     = PG_W + 1;
  localparam int KS_DEPTH = ROWS * MAX_PAGES * HEAD_DIM_MAX;
  localparam int KS_W     = $clog2(KS_DEPTH);
  localparam int CNT_W    = (ROW_W > NP_W) ? ROW_W : NP_W;
  localparam int KK_W     = (NP_W + 1 > 7) ? NP_W + 1 : 7;
  localparam int DIV_W    = 16;
  localparam int DVS_W    = 9;
  localparam int SCORE_W  = 48;
  localparam int PROD_W   = 32;

  localparam logic [8:0] PS_DEFAULT = 9'd16;

  typedef enum logic [1:0] {
    REQ_KEY   = 2'd0,
    REQ_QUERY = 2'd1,
    REQ_CLEAR = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  localparam logic [2:0] CFG_ENABLE     = 3'd0;
  localparam logic [2:0] CFG_PG_TOKENS  = 3'd1;
  localparam logic [2:0] CFG_PG_FLOOR   = 3'd2;
  localparam logic [2:0] CFG_KEEP_FRAC  = 3'd3;
  localparam logic [2:0] CFG_Q_HEADS    = 3'd4;
  localparam logic [2:0] CFG_KV_HEADS   = 3'd5;
  localparam logic [2:0] CFG_HEAD_DIM   = 3'd6;

  typedef struct packed {
    logic        enable;
    logic [8:0]  pg_tokens;
    logic [6:0]  pg_floor;
    logic [16:0] keep_fraction;
    logic [6:0]  query_heads;
    logic [3:0]  kv_heads;
    logic [7:0]  head_dim_used;
  } cfg_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LATCH,
    OP_VCLR,
    OP_DIV_PAGE,
    OP_KEY_RD,
    OP_KEY_WR,
    OP_DIV_RATIO,
    OP_DIV_KVH,
    OP_VLATCH,
    OP_Q_MUL,
    OP_Q_ACC,
    OP_DIV_NP,
    OP_KEEPK,
    OP_ACT_INIT,
    OP_RK_LDP,
    OP_RK_CMP,
    OP_RK_DEC,
    OP_EMIT,
    OP_SCLR
  } dp_op_t;

  typedef struct packed {
    dp_op_t           op;
    logic [CNT_W-1:0] idx;
    logic [PG_W-1:0]  ridx;
  } cmd_t;

  typedef struct packed {
    logic            enable;
    logic            div_done;
    logic            key_ok;
    logic            q_ok;
    logic            quo_zero;
    logic            kvh_ok;
    logic            last_el;
    logic            ctx_zero;
    logic            need_rank;
    logic [NP_W-1:0] np;
    logic [NP_W-1:0] end_cand;
  } st_t;

endpackage

>>> rtl/kvps_ram.sv
// Generic single-write, single-read RAM with registered read data.
module kvps_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/kvps_div.sv
// Restoring divider, one quotient bit per cycle.
module kvps_div
  import kvps_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DIV_W-1:0] quotient
);

  localparam int CW = $clog2(DIV_W + 1);

  logic [DVS_W-1:0] rem_r, rem_nxt, dvs_r;
  logic [DIV_W-1:0] quo_r;
  logic [CW-1:0]    cnt_r;
  logic             run_r, done_r;
  logic [DVS_W:0]   trial;
  logic             ge;

  always_comb begin
    trial   = {rem_r, quo_r[DIV_W-1]};
    ge      = trial >= {1'b0, dvs_r};
    rem_nxt = ge ? DVS_W'(trial - {1'b0, dvs_r}) : trial[DVS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= CW'(DIV_W);
        rem_r <= '0;
        quo_r <= dividend;
        dvs_r <= divisor;
      end else if (run_r) begin
        rem_r <= rem_nxt;
        quo_r <= {quo_r[DIV_W-2:0], ge};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

>>> rtl/kvps_ctrl.sv
// Sequencer: steps the datapath through clear, key, query, select and emit phases.
module kvps_ctrl
  import kvps_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic [1:0] req_type,
  input  st_t        st,
  output cmd_t       cmd,
  output logic       busy
);

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_KDIV, S_KWAIT, S_KCHK, S_KWR,
    S_QRAT, S_QRW, S_QKVH, S_QKW, S_QKCHK, S_QVL, S_QRD, S_QMUL, S_QACC, S_QEND,
    S_NP, S_NPW, S_KK, S_SEL0, S_RLD, S_RLD2, S_RCMP, S_RFIN, S_RDEC,
    S_EMIT, S_SCLR
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [PG_W-1:0]  rcnt_r, rcnt_nxt;
  logic             busy_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    rcnt_nxt  = rcnt_r;
    cmd.op    = OP_NONE;
    cmd.idx   = cnt_r;
    cmd.ridx  = rcnt_r;
    unique case (state_r)
      S_CLR: begin
        cmd.op  = OP_VCLR;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(ROWS - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.op = OP_LATCH;
          priority case (req_type)
            REQ_KEY:   state_nxt = st.enable ? S_KDIV : S_IDLE;
            REQ_QUERY: state_nxt = S_QRAT;
            REQ_CLEAR: begin
              state_nxt = S_CLR;
              cnt_nxt   = '0;
            end
            default:   state_nxt = S_IDLE;
          endcase
        end
      end
      S_KDIV: begin
        cmd.op    = OP_DIV_PAGE;
        state_nxt = S_KWAIT;
      end
      S_KWAIT: if (st.div_done) state_nxt = S_KCHK;
      S_KCHK: begin
        if (st.key_ok) begin
          cmd.op    = OP_KEY_RD;
          state_nxt = S_KWR;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_KWR: begin
        cmd.op    = OP_KEY_WR;
        state_nxt = S_IDLE;
      end
      S_QRAT: begin
        if (st.q_ok) begin
          cmd.op    = OP_DIV_RATIO;
          state_nxt = S_QRW;
        end else begin
          state_nxt = S_QEND;
        end
      end
      S_QRW: if (st.div_done) state_nxt = S_QKVH;
      S_QKVH: begin
        if (st.quo_zero) begin
          state_nxt = S_QEND;
        end else begin
          cmd.op    = OP_DIV_KVH;
          state_nxt = S_QKW;
        end
      end
      S_QKW: if (st.div_done) state_nxt = S_QKCHK;
      S_QKCHK: state_nxt = st.kvh_ok ? S_QVL : S_QEND;
      S_QVL: begin
        cmd.op    = OP_VLATCH;
        cnt_nxt   = '0;
        state_nxt = S_QRD;
      end
      S_QRD: state_nxt = S_QMUL;
      S_QMUL: begin
        cmd.op    = OP_Q_MUL;
        state_nxt = S_QACC;
      end
      S_QACC: begin
        cmd.op  = OP_Q_ACC;
        cnt_nxt = cnt_r + 1'b1;
        state_nxt = (cnt_r == CNT_W'(MAX_PAGES - 1)) ? S_QEND : S_QRD;
      end
      S_QEND: state_nxt = st.last_el ? S_NP : S_IDLE;
      S_NP: begin
        if (st.ctx_zero) begin
          state_nxt = S_SCLR;
        end else begin
          cmd.op    = OP_DIV_NP;
          state_nxt = S_NPW;
        end
      end
      S_NPW: if (st.div_done) state_nxt = S_KK;
      S_KK: begin
        cmd.op    = OP_KEEPK;
        state_nxt = S_SEL0;
      end
      S_SEL0: begin
        cmd.op = OP_ACT_INIT;
        if (st.need_rank) begin
          cnt_nxt   = CNT_W'(1);
          state_nxt = S_RLD;
        end else begin
          cnt_nxt   = '0;
          state_nxt = S_EMIT;
        end
      end
      S_RLD: state_nxt = S_RLD2;
      S_RLD2: begin
        cmd.op    = OP_RK_LDP;
        rcnt_nxt  = PG_W'(1);
        state_nxt = S_RCMP;
      end
      S_RCMP: begin
        cmd.op   = OP_RK_CMP;
        rcnt_nxt = rcnt_r + 1'b1;
        if (rcnt_r == PG_W'(st.end_cand - 1'b1)) state_nxt = S_RFIN;
      end
      S_RFIN: state_nxt = S_RDEC;
      S_RDEC: begin
        cmd.op = OP_RK_DEC;
        if (cnt_r == CNT_W'(st.end_cand - 1'b1)) begin
          cnt_nxt   = '0;
          state_nxt = S_EMIT;
        end else begin
          cnt_nxt   = cnt_r + 1'b1;
          state_nxt = S_RLD;
        end
      end
      S_EMIT: begin
        cmd.op  = OP_EMIT;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(st.np - 1'b1)) state_nxt = S_SCLR;
      end
      S_SCLR: begin
        cmd.op    = OP_SCLR;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      cnt_r   <= '0;
      rcnt_r  <= '0;
      busy_r  <= 1'b1;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      rcnt_r  <= rcnt_nxt;
      busy_r  <= (state_nxt != S_IDLE);
    end
  end

  assign busy = busy_r;

  a_busy_state: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r == (state_r != S_IDLE)) else $error("busy out of step with state");

  a_clr_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLR && cnt_r != CNT_W'(ROWS - 1)) |=> state_r == S_CLR)
    else $error("clearing pass cut short");

  a_rank_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RCMP && state_nxt == S_RCMP) |=> rcnt_r == $past(rcnt_r) + 1'b1)
    else $error("rank walk skipped a page");

endmodule

>>> rtl/kvps_dp.sv
// Datapath: bound stores, valid rows, score store, divider and selection logic.
module kvps_dp
  import kvps_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  cfg_t               cfg,
  input  cmd_t               cmd,
  input  logic [4:0]         in_layer,
  input  logic [5:0]         in_head,
  input  logic [13:0]        in_token_pos,
  input  logic [6:0]         in_dim,
  input  logic signed [15:0] in_value,
  input  logic [14:0]        in_context_len,
  input  logic               in_last_element,
  output st_t                st,
  output logic               out_valid,
  output logic [5:0]         out_page_index,
  output logic               out_active,
  output logic               out_last,
  output logic               out_truncated
);

  // latched request
  logic [4:0]         layer_r;
  logic [5:0]         head_r;
  logic [13:0]        pos_r;
  logic [6:0]         dim_r;
  logic signed [15:0] val_r;
  logic [14:0]        ctx_r;
  logic               last_r;

  logic [8:0] ps_eff;
  assign ps_eff = (cfg.pg_tokens == 9'd0) ? PS_DEFAULT : cfg.pg_tokens;

  // divider
  logic             div_start, div_done;
  logic [DIV_W-1:0] div_a, quo;
  logic [DVS_W-1:0] div_b;

  always_comb begin
    div_start = 1'b1;
    div_a     = '0;
    div_b     = ps_eff;
    unique case (cmd.op)
      OP_DIV_PAGE:  div_a = DIV_W'(pos_r);
      OP_DIV_RATIO: begin
        div_a = DIV_W'(cfg.query_heads);
        div_b = DVS_W'(cfg.kv_heads);
      end
      OP_DIV_KVH: begin
        div_a = DIV_W'(head_r);
        div_b = quo[DVS_W-1:0];
      end
      OP_DIV_NP:    div_a = DIV_W'(ctx_r) + DIV_W'(ps_eff) - 1'b1;
      default:      div_start = 1'b0;
    endcase
  end

  kvps_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quotient (quo)
  );

  // addressing
  logic            dim_ok;
  logic [ROW_W-1:0] row_key, row_q;
  logic [PG_W-1:0] page_key;
  logic [KS_W-1:0] ka_key, ka_q;

  assign dim_ok   = (int'(dim_r) < int'(cfg.head_dim_used)) && (int'(dim_r) < HEAD_DIM_MAX);
  assign page_key = quo[PG_W-1:0];
  assign row_key  = ROW_W'(int'(layer_r) * KV_HEADS_MAX + int'(head_r));
  assign row_q    = ROW_W'(int'(layer_r) * KV_HEADS_MAX + int'(quo));
  assign ka_key   = KS_W'((int'(row_key) * MAX_PAGES + int'(page_key)) * HEAD_DIM_MAX
                          + int'(dim_r));
  assign ka_q     = KS_W'((int'(row_q) * MAX_PAGES + int'(cmd.idx[PG_W-1:0]))
                          * HEAD_DIM_MAX + int'(dim_r));

  // bound stores
  logic [15:0]        kmin_q, kmax_q, kmin_w, kmax_w;
  logic               ks_we;
  logic [KS_W-1:0]    ks_ra;
  logic [MAX_PAGES-1:0] vrow_q, vrow_w, vrow_r;
  logic               vb, v_we;
  logic [ROW_W-1:0]   v_ra, v_wa;

  assign ks_ra = (cmd.op == OP_KEY_RD) ? ka_key : ka_q;
  assign vb    = vrow_q[page_key];
  assign ks_we = (cmd.op == OP_KEY_WR) && dim_ok;
  assign kmin_w = (!vb || (val_r < $signed(kmin_q))) ? val_r : kmin_q;
  assign kmax_w = (!vb || (val_r > $signed(kmax_q))) ? val_r : kmax_q;

  kvps_ram #(.WIDTH(16), .DEPTH(KS_DEPTH)) u_kmin (
    .clk(clk), .we(ks_we), .waddr(ka_key), .wdata(kmin_w), .raddr(ks_ra), .rdata(kmin_q)
  );
  kvps_ram #(.WIDTH(16), .DEPTH(KS_DEPTH)) u_kmax (
    .clk(clk), .we(ks_we), .waddr(ka_key), .wdata(kmax_w), .raddr(ks_ra), .rdata(kmax_q)
  );

  assign v_ra   = (cmd.op == OP_KEY_RD) ? row_key : row_q;
  assign v_we   = ((cmd.op == OP_KEY_WR) && last_r) || (cmd.op == OP_VCLR);
  assign v_wa   = (cmd.op == OP_VCLR) ? cmd.idx[ROW_W-1:0] : row_key;
  assign vrow_w = (cmd.op == OP_VCLR) ? '0 : (vrow_q | (MAX_PAGES'(1) << page_key));

  kvps_ram #(.WIDTH(MAX_PAGES), .DEPTH(ROWS)) u_valid (
    .clk(clk), .we(v_we), .waddr(v_wa), .wdata(vrow_w), .raddr(v_ra), .rdata(vrow_q)
  );

  // score store; an entry without its flag reads as zero
  logic [MAX_PAGES-1:0] sc_vld_r;
  logic [PG_W-1:0]      sc_ra, sc_ra_d;
  logic [SCORE_W-1:0]   sc_q, sc_w;
  logic                 sc_we;
  logic signed [SCORE_W-1:0] sc_rd;
  logic signed [PROD_W-1:0]  pa_r, pb_r, best;
  logic signed [SCORE_W:0]   sum;

  assign sc_ra = (cmd.op == OP_RK_CMP) ? cmd.ridx : cmd.idx[PG_W-1:0];
  assign sc_rd = sc_vld_r[sc_ra_d] ? $signed(sc_q) : '0;
  assign best  = (pa_r > pb_r) ? pa_r : pb_r;
  assign sum   = {sc_rd[SCORE_W-1], sc_rd} + (SCORE_W+1)'(best);

  always_comb begin
    sc_w = sum[SCORE_W-1:0];
    if (sum[SCORE_W] != sum[SCORE_W-1]) begin
      sc_w = sum[SCORE_W] ? {1'b1, {(SCORE_W-1){1'b0}}} : {1'b0, {(SCORE_W-1){1'b1}}};
    end
  end

  assign sc_we = (cmd.op == OP_Q_ACC) && vrow_r[cmd.idx[PG_W-1:0]];

  kvps_ram #(.WIDTH(SCORE_W), .DEPTH(MAX_PAGES)) u_score (
    .clk(clk), .we(sc_we), .waddr(cmd.idx[PG_W-1:0]), .wdata(sc_w),
    .raddr(sc_ra), .rdata(sc_q)
  );

  // selection
  logic [NP_W-1:0] np_r, np_sat, retained, end_cand;
  logic            trunc_r, quo_over, all_act, cmp_v_r;
  logic [KK_W-1:0] keepk_r, frac, kk_nxt, budget;
  logic [17+NP_W-1:0] fprod;
  logic [PG_W-1:0] r_d;
  logic signed [SCORE_W-1:0] sp_r;
  logic [6:0]      rank_r;
  logic [MAX_PAGES-1:0] act_r;

  assign quo_over = quo > DIV_W'(MAX_PAGES);
  assign np_sat   = quo_over ? NP_W'(MAX_PAGES) : quo[NP_W-1:0];
  assign fprod    = cfg.keep_fraction * np_sat;
  assign frac     = KK_W'(fprod[17+NP_W-1:16]);
  assign kk_nxt   = (frac > KK_W'(cfg.pg_floor)) ? frac : KK_W'(cfg.pg_floor);

  assign all_act  = !cfg.enable || (np_r <= cfg.pg_floor) || (keepk_r >= KK_W'(np_r));
  assign retained = (np_r < NP_W'(3)) ? np_r : NP_W'(3);
  assign end_cand = (np_r > NP_W'(2)) ? np_r - NP_W'(2) : NP_W'(1);
  assign budget   = keepk_r - KK_W'(retained);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sc_vld_r  <= '0;
      cmp_v_r   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      cmp_v_r   <= (cmd.op == OP_RK_CMP);
      out_valid <= (cmd.op == OP_EMIT);
      if (sc_we) sc_vld_r[cmd.idx[PG_W-1:0]] <= 1'b1;
      if (cmd.op == OP_SCLR) sc_vld_r <= '0;
    end
  end

  always_ff @(posedge clk) begin
    sc_ra_d <= sc_ra;
    r_d     <= cmd.ridx;
    if (cmp_v_r && ((sc_rd > sp_r) || ((sc_rd == sp_r) && (r_d < cmd.idx[PG_W-1:0])))) begin
      rank_r <= rank_r + 1'b1;
    end
    unique case (cmd.op)
      OP_LATCH: begin
        layer_r <= in_layer;
        head_r  <= in_head;
        pos_r   <= in_token_pos;
        dim_r   <= in_dim;
        val_r   <= in_value;
        ctx_r   <= in_context_len;
        last_r  <= in_last_element;
      end
      OP_VLATCH: vrow_r <= vrow_q;
      OP_Q_MUL: begin
        pa_r <= val_r * $signed(kmin_q);
        pb_r <= val_r * $signed(kmax_q);
      end
      OP_KEEPK: begin
        np_r    <= np_sat;
        trunc_r <= quo_over;
        keepk_r <= kk_nxt;
      end
      OP_ACT_INIT: begin
        for (int p = 0; p < MAX_PAGES; p++) begin
          act_r[p] <= all_act || (p == 0) || (NP_W'(p + 1) == np_r)
                      || (NP_W'(p + 2) == np_r);
        end
      end
      OP_RK_LDP: begin
        sp_r   <= sc_rd;
        rank_r <= '0;
      end
      OP_RK_DEC: act_r[cmd.idx[PG_W-1:0]] <= KK_W'(rank_r) < budget;
      OP_EMIT: begin
        out_page_index <= 6'(cmd.idx[PG_W-1:0]);
        out_active     <= act_r[cmd.idx[PG_W-1:0]];
        out_last       <= (NP_W'(cmd.idx) + 1'b1) == np_r;
        out_truncated  <= trunc_r;
      end
      default: ;
    endcase
  end

  always_comb begin
    st.enable    = cfg.enable;
    st.div_done  = div_done;
    st.key_ok    = (int'(layer_r) < LAYERS) && (head_r < 6'(cfg.kv_heads))
                   && (int'(head_r) < KV_HEADS_MAX) && (quo < DIV_W'(MAX_PAGES));
    st.q_ok      = (int'(layer_r) < LAYERS) && ({1'b0, head_r} < cfg.query_heads)
                   && (cfg.kv_heads != 4'd0) && dim_ok;
    st.quo_zero  = (quo == '0);
    st.kvh_ok    = (quo < DIV_W'(cfg.kv_heads)) && (quo < DIV_W'(KV_HEADS_MAX));
    st.last_el   = last_r;
    st.ctx_zero  = (ctx_r == '0);
    st.need_rank = !all_act && (KK_W'(retained) < keepk_r) && (end_cand > NP_W'(1));
    st.np        = np_r;
    st.end_cand  = end_cand;
  end

  a_emit_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |=> out_valid && out_page_index == $past(out_page_index) + 1'b1)
    else $error("page results out of sequence");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |=> !out_valid) else $error("result after last page");

  a_first_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_page_index == 6'd0) |-> out_active) else $error("page zero dropped");

endmodule

>>> rtl/kv_page_topk_selector_core.sv
// Top level of the query-aware KV page selector: config registers, sequencer, datapath.
//
//  channel | ports                                   | transfer
//  --------+-----------------------------------------+-------------------------------
//  input   | start, busy, in_*                       | start && !busy at clk edge
//  result  | out_valid, out_page_index/active/...    | out_valid, one cycle, no stall
//  config  | cfg_we, cfg_index, cfg_wdata            | cfg_we at clk edge
//
// After reset the valid-bit rows are swept clear with busy high.
// A clear request repeats that sweep.
// Key element: a page division in the divider, then a RAM read-modify-write.
// Query element: 2 divider passes, then a loop over all 64 pages
//   (bound read, multiply and score accumulate per page, not overlapped).
// Last query element adds np division and an O(n^2) rank walk over the candidates,
//   then emits one page per cycle. Results cannot be stalled.
module kv_page_topk_selector_core
  import kvps_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_req_type,
  input  logic [4:0]         in_layer,
  input  logic [5:0]         in_head,
  input  logic [13:0]        in_token_pos,
  input  logic [6:0]         in_dim,
  input  logic signed [15:0] in_value,
  input  logic [14:0]        in_context_len,
  input  logic               in_last_element,
  output logic               out_valid,
  output logic [5:0]         out_page_index,
  output logic               out_active,
  output logic               out_last,
  output logic               out_truncated,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [16:0]        cfg_wdata
);

  cfg_t cfg_r;
  cmd_t cmd;
  st_t  st;

  // config registers; writes outside the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enable        <= 1'b0;
      cfg_r.pg_tokens     <= 9'd16;
      cfg_r.pg_floor      <= 7'd0;
      cfg_r.keep_fraction <= 17'd65536;
      cfg_r.query_heads   <= 7'd32;
      cfg_r.kv_heads      <= 4'd8;
      cfg_r.head_dim_used <= 8'd128;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ENABLE:    cfg_r.enable        <= cfg_wdata[0];
        CFG_PG_TOKENS: cfg_r.pg_tokens     <= cfg_wdata[8:0];
        CFG_PG_FLOOR:  cfg_r.pg_floor      <= cfg_wdata[6:0];
        CFG_KEEP_FRAC: cfg_r.keep_fraction <= cfg_wdata;
        CFG_Q_HEADS:   cfg_r.query_heads   <= cfg_wdata[6:0];
        CFG_KV_HEADS:  cfg_r.kv_heads      <= cfg_wdata[3:0];
        CFG_HEAD_DIM:  cfg_r.head_dim_used <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  kvps_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .req_type (in_req_type),
    .st       (st),
    .cmd      (cmd),
    .busy     (busy)
  );

  kvps_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .cmd             (cmd),
    .in_layer        (in_layer),
    .in_head         (in_head),
    .in_token_pos    (in_token_pos),
    .in_dim          (in_dim),
    .in_value        (in_value),
    .in_context_len  (in_context_len),
    .in_last_element (in_last_element),
    .st              (st),
    .out_valid       (out_valid),
    .out_page_index  (out_page_index),
    .out_active      (out_active),
    .out_last        (out_last),
    .out_truncated   (out_truncated)
  );

endmodule

>>> sim/kv_page_topk_selector_core_tb.sv
// Self-checking testbench for the KV page selector core: page bound tracking and top-k pick.
module kv_page_topk_selector_core_tb;
  import kvps_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 40000;  // idle cycles

  typedef struct {
    int  pg;
    bit  act;
    bit  lst;
    bit  trunc;
  } page_flag_t;

  typedef struct {
    req_t              req;
    logic [4:0]        layer;
    logic [5:0]        head;
    logic [13:0]       pos;
    logic [6:0]        dim;
    logic signed [15:0] value;
    logic [14:0]       ctx;
    logic              last;
  } elem_t;

  // Scoreboard: shadow copy of bounds, valid bits and scores; queue of page flags due.
  class kvps_scoreboard;
    bit          en;
    int unsigned psz, minp, kfrac, qh, kvh, hdu;
    shortint     kmin[int];
    shortint     kmax[int];
    bit          pvalid[int];
    longint      score[MAX_PAGES];
    page_flag_t  flags_due[$];
    int          errors;

    function new();
      en = 0; psz = 16; minp = 0; kfrac = 65536; qh = 32; kvh = 8; hdu = 128;
      foreach (score[i]) score[i] = 0;
      errors = 0;
    endfunction

    task report(string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      errors++;
    endtask

    function void set_cfg(logic [2:0] idx, logic [16:0] val);
      case (idx)
        CFG_ENABLE:    en    = val[0];
        CFG_PG_TOKENS: psz   = val[8:0];
        CFG_PG_FLOOR:  minp  = val[6:0];
        CFG_KEEP_FRAC: kfrac = val;
        CFG_Q_HEADS:   qh    = val[6:0];
        CFG_KV_HEADS:  kvh   = val[3:0];
        CFG_HEAD_DIM:  hdu   = val[7:0];
        default: ;
      endcase
    endfunction

    function int row_of(int layer, int h, int pg);
      return (layer * KV_HEADS_MAX + h) * MAX_PAGES + pg;
    endfunction

    // kv head a query element maps to, or -1 when it adds nothing
    function int map_query(int layer, int head, int dim);
      int ratio;
      if (layer >= LAYERS || head >= qh || kvh == 0 || dim >= hdu || dim >= HEAD_DIM_MAX)
        return -1;
      ratio = qh / kvh;
      if (ratio == 0) return -1;
      if (head / ratio >= kvh || head / ratio >= KV_HEADS_MAX) return -1;
      return head / ratio;
    endfunction

    // true if this query element would read a bound entry never written
    function bit reads_unwritten(int layer, int head, int dim);
      int m;
      int pv;
      m = map_query(layer, head, dim);
      if (m < 0) return 0;
      for (int p = 0; p < MAX_PAGES; p++) begin
        pv = row_of(layer, m, p);
        if (pvalid.exists(pv) && !kmin.exists(pv * HEAD_DIM_MAX + dim)) return 1;
      end
      return 0;
    endfunction

    // true if this key element would merge into a bound entry never written
    function bit key_hits_unwritten(elem_t e);
      int unsigned ps, pg;
      int pv;
      ps = psz ? psz : 16;
      pg = e.pos / ps;
      if (!en || e.layer >= LAYERS || e.head >= kvh || e.head >= KV_HEADS_MAX ||
          pg >= MAX_PAGES || e.dim >= hdu || e.dim >= HEAD_DIM_MAX)
        return 0;
      pv = row_of(e.layer, e.head, pg);
      return pvalid.exists(pv) && !kmin.exists(pv * HEAD_DIM_MAX + e.dim);
    endfunction

    function void pick_pages(int ctx);
      int unsigned ps, np, frac, keep, retained, budget, endc, rank;
      bit trunc;
      bit act[MAX_PAGES];
      page_flag_t f;
      if (ctx == 0) return;
      ps = psz ? psz : 16;
      np = (ctx + ps - 1) / ps;
      trunc = 0;
      if (np > MAX_PAGES) begin
        np = MAX_PAGES;
        trunc = 1;
      end
      for (int p = 0; p < MAX_PAGES; p++) act[p] = 1;
      if (en && np > minp) begin
        frac = (longint'(kfrac) * np) >> 16;
        keep = frac > minp ? frac : minp;
        if (keep < np) begin
          for (int p = 0; p < MAX_PAGES; p++) act[p] = 0;
          act[0] = 1;
          if (np > 1) act[np-1] = 1;
          if (np > 2) act[np-2] = 1;
          retained = np < 3 ? np : 3;
          if (retained < keep) begin
            budget = keep - retained;
            endc = np > 2 ? np - 2 : 1;
            for (int p = 1; p < endc; p++) begin
              rank = 0;
              for (int r = 1; r < endc; r++)
                if (score[r] > score[p] || (score[r] == score[p] && r < p)) rank++;
              if (rank < budget) act[p] = 1;
            end
          end
        end
      end
      for (int p = 0; p < np; p++) begin
        f.pg = p; f.act = act[p]; f.lst = (p + 1 == np); f.trunc = trunc;
        flags_due = {flags_due, f};
      end
    endfunction

    // called for each accepted input transfer
    function void note(elem_t e);
      int unsigned ps, pg;
      int pv, ki, m;
      int a, b;
      longint s;
      case (e.req)
        REQ_KEY: begin
          ps = psz ? psz : 16;
          pg = e.pos / ps;
          if (en && e.layer < LAYERS && e.head < kvh && e.head < KV_HEADS_MAX &&
              pg < MAX_PAGES) begin
            pv = row_of(e.layer, e.head, pg);
            if (e.dim < hdu && e.dim < HEAD_DIM_MAX) begin
              ki = pv * HEAD_DIM_MAX + e.dim;
              if (!pvalid.exists(pv) || !kmin.exists(ki)) begin
                kmin[ki] = e.value;
                kmax[ki] = e.value;
              end else begin
                if (e.value < kmin[ki]) kmin[ki] = e.value;
                if (e.value > kmax[ki]) kmax[ki] = e.value;
              end
            end
            if (e.last) pvalid[pv] = 1;
          end
        end
        REQ_CLEAR: pvalid.delete();
        REQ_QUERY: begin
          m = map_query(e.layer, e.head, e.dim);
          if (m >= 0)
            for (int p = 0; p < MAX_PAGES; p++) begin
              pv = row_of(e.layer, m, p);
              if (!pvalid.exists(pv)) continue;
              ki = pv * HEAD_DIM_MAX + e.dim;
              a = int'(e.value) * int'(kmin[ki]);
              b = int'(e.value) * int'(kmax[ki]);
              s = score[p] + longint'(a > b ? a : b);
              if (s > 64'sh7FFF_FFFF_FFFF) s = 64'sh7FFF_FFFF_FFFF;
              if (s < -64'sh8000_0000_0000) s = -64'sh8000_0000_0000;
              score[p] = s;
            end
          if (e.last) begin
            pick_pages(e.ctx);
            foreach (score[i]) score[i] = 0;
          end
        end
        default: ;
      endcase
    endfunction

    // called for each result transfer
    task check(int pg, bit act, bit lst, bit trunc);
      page_flag_t f;
      if (flags_due.size() == 0) begin
        report($sformatf("unexpected result page %0d", pg));
        return;
      end
      f = flags_due.pop_front();
      if (pg != f.pg || act != f.act || lst != f.lst || trunc != f.trunc)
        report($sformatf("page %0d act %0d last %0d trunc %0d, want %0d %0d %0d %0d",
                         pg, act, lst, trunc, f.pg, f.act, f.lst, f.trunc));
    endtask
  endclass

  logic               clk = 0;
  logic               rst_n = 0;
  logic               start = 0;
  logic               busy;
  logic [1:0]         in_req_type = '0;
  logic [4:0]         in_layer = '0;
  logic [5:0]         in_head = '0;
  logic [13:0]        in_token_pos = '0;
  logic [6:0]         in_dim = '0;
  logic signed [15:0] in_value = '0;
  logic [14:0]        in_context_len = '0;
  logic               in_last_element = 0;
  logic               out_valid;
  logic [5:0]         out_page_index;
  logic               out_active;
  logic               out_last;
  logic               out_truncated;
  logic               cfg_we = 0;
  logic [2:0]         cfg_index = '0;
  logic [16:0]        cfg_wdata = '0;

  kvps_scoreboard sb = new();
  int idle_pct;     // chance in 100 that the sender idles another cycle
  int sent;         // counted transfers in the current phase
  int wd_cnt = 0;

  kv_page_topk_selector_core i_dut (.*);

  always #4 clk = ~clk;

  // result monitor: sample at the rising edge, before the block updates
  always @(posedge clk)
    if (rst_n && out_valid)
      sb.check(out_page_index, out_active, out_last, out_truncated);

  // watchdog: cycles with neither an input nor a result transfer
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || !rst_n) wd_cnt <= 0;
    else wd_cnt <= wd_cnt + 1;
    if (wd_cnt >= WATCHDOG_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic cfg_write(logic [2:0] idx, int val);
    @(negedge clk);
    cfg_we = 1; cfg_index = idx; cfg_wdata = 17'(val);
    sb.set_cfg(idx, 17'(val));
    @(negedge clk);
    cfg_we = 0;
  endtask

  task automatic set_all(int en, int ps, int mp, int kf, int q, int kv, int hd);
    cfg_write(CFG_ENABLE, en);
    cfg_write(CFG_PG_TOKENS, ps);
    cfg_write(CFG_PG_FLOOR, mp);
    cfg_write(CFG_KEEP_FRAC, kf);
    cfg_write(CFG_Q_HEADS, q);
    cfg_write(CFG_KV_HEADS, kv);
    cfg_write(CFG_HEAD_DIM, hd);
  endtask

  // drain results, then let the block finish its own work before touching config
  task automatic wait_idle();
    do @(posedge clk); while (sb.flags_due.size() != 0 || busy);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  // one input transfer; called right after a falling edge
  task automatic send(elem_t e);
    if (e.req == REQ_QUERY && sb.reads_unwritten(e.layer, e.head, e.dim)) begin
      // steer away from bound entries that were never written
      if (sb.hdu < HEAD_DIM_MAX) e.dim = 7'(sb.hdu);
      else if (sb.qh < 64) e.head = 6'd63;
      else e.req = REQ_NONE;
    end
    if (e.req == REQ_KEY && sb.key_hits_unwritten(e)) begin
      if (sb.hdu < HEAD_DIM_MAX) e.dim = 7'(sb.hdu);
      else e.req = REQ_NONE;
    end
    while ($urandom_range(99) < idle_pct) begin
      start = 0;
      @(negedge clk);
    end
    in_req_type = e.req; in_layer = e.layer; in_head = e.head; in_token_pos = e.pos;
    in_dim = e.dim; in_value = e.value; in_context_len = e.ctx; in_last_element = e.last;
    start = 1;
    do @(posedge clk); while (busy);
    sb.note(e);
    if (e.req != REQ_NONE) sent++;
    @(negedge clk);
    start = 0;
  endtask

  function automatic elem_t mk(req_t r, int layer, int head, int pos, int dim, int val,
                               int ctx, bit last);
    elem_t e;
    e.req = r; e.layer = 5'(layer); e.head = 6'(head); e.pos = 14'(pos); e.dim = 7'(dim);
    e.value = 16'(val); e.ctx = 15'(ctx); e.last = last;
    return e;
  endfunction

  function automatic int pick_layer();
    int r;
    r = $urandom_range(9);
    return r < 4 ? 0 : (r < 8 ? 31 : $urandom_range(31));
  endfunction

  function automatic int vec_len();
    return sb.hdu > 4 ? 4 : sb.hdu;
  endfunction

  // key vector for one page; cut short when broken is set
  task automatic key_vec(int layer, int h, int pg, bit broken);
    int ps, pos, n;
    ps = sb.psz ? sb.psz : 16;
    n = broken ? $urandom_range(vec_len() - 1) : vec_len();
    for (int d = 0; d < n; d++) begin
      pos = pg * ps + $urandom_range(ps - 1);
      if (pos > 16383) pos = 16383;
      send(mk(REQ_KEY, layer, h, pos, d, $urandom_range(65535), $urandom_range(32767),
              !broken && d == n - 1));
    end
  endtask

  task automatic query_vec(int layer, int h, int ctx, bit broken);
    int n;
    n = vec_len();
    for (int d = 0; d < n; d++)
      send(mk(REQ_QUERY, layer, h, $urandom_range(16383), d, $urandom_range(65535), ctx,
              !broken && d == n - 1));
  endtask

  task automatic run_phase(int n_items, int ctx_max);
    int r, ps, pg_top, ctx;
    ps = sb.psz ? sb.psz : 16;
    pg_top = (ctx_max - 1) / ps;
    if (pg_top > MAX_PAGES - 1) pg_top = MAX_PAGES - 1;
    sent = 0;
    while (sent < n_items) begin
      r = $urandom_range(99);
      if (r < 45) begin
        key_vec(pick_layer(), $urandom_range(sb.kvh - 1),
                ($urandom_range(19) == 0) ? $urandom_range(70) : $urandom_range(pg_top), 0);
      end else if (r < 78) begin
        ctx = $urandom_range(19);
        ctx = (ctx == 0) ? 0 : (ctx == 1) ? 16384 : $urandom_range(ctx_max, 1);
        query_vec(pick_layer(), $urandom_range(sb.qh - 1), ctx, 0);
      end else if (r < 88) begin
        // noise: any field, any code
        send(mk(req_t'($urandom_range(3)), $urandom_range(31), $urandom_range(63),
                $urandom_range(16383), $urandom_range(127), $urandom_range(65535),
                $urandom_range(16384), $urandom_range(1)));
      end else if (r < 91) begin
        send(mk(REQ_CLEAR, 0, 0, 0, 0, 0, 0, 0));
      end else if (r < 96) begin
        key_vec(pick_layer(), $urandom_range(sb.kvh - 1), $urandom_range(pg_top), 1);
      end else begin
        query_vec(pick_layer(), $urandom_range(sb.qh - 1), 1, 1);
      end
    end
  endtask

  initial begin
    idle_pct = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // directed part
    set_all(1, 16, 0, 32768, 8, 2, 2);
    send(mk(REQ_NONE, 3, 5, 100, 1, 1234, 99, 1));          // ignored code
    send(mk(REQ_KEY, 0, 0, 16, 0, -32768, 0, 0));           // value extremes
    send(mk(REQ_KEY, 0, 0, 17, 1, 32767, 0, 1));
    send(mk(REQ_KEY, 0, 0, 40, 0, 4096, 0, 0));
    send(mk(REQ_KEY, 0, 0, 41, 1, -4096, 0, 1));
    send(mk(REQ_KEY, 0, 0, 40, 0, 8192, 0, 1));             // widens bounds of a valid page
    send(mk(REQ_KEY, 0, 2, 48, 0, 77, 0, 1));               // kv head out of range
    send(mk(REQ_KEY, 0, 0, 16383, 0, 77, 0, 1));            // page beyond the table
    send(mk(REQ_KEY, 5, 1, 64, 5, 77, 0, 1));               // dim out of range still validates
    send(mk(REQ_QUERY, 0, 0, 0, 0, 32767, 0, 0));
    send(mk(REQ_QUERY, 0, 1, 0, 1, -32768, 100, 1));        // seven pages, only first and last two kept
    send(mk(REQ_QUERY, 0, 0, 0, 0, 100, 0, 1));             // empty context
    send(mk(REQ_QUERY, 0, 0, 0, 0, 100, 16384, 1));         // saturated page count
    send(mk(REQ_QUERY, 0, 0, 0, 0, 100, 16, 1));            // one page
    send(mk(REQ_QUERY, 0, 0, 0, 0, 100, 17, 1));            // two pages
    send(mk(REQ_QUERY, 0, 63, 0, 0, 100, 48, 1));           // unmapped head
    send(mk(REQ_CLEAR, 0, 0, 0, 0, 0, 0, 0));
    send(mk(REQ_QUERY, 0, 0, 0, 0, 100, 100, 1));           // no bounds, all scores zero
    wait_idle();
    cfg_write(CFG_ENABLE, 0);
    send(mk(REQ_QUERY, 0, 0, 0, 0, 100, 50, 1));            // disabled: all active
    wait_idle();
    set_all(1, 16, 64, 0, 8, 2, 2);
    send(mk(REQ_QUERY, 0, 0, 0, 0, 100, 200, 1));           // at or below min pages
    wait_idle();
    cfg_write(CFG_PG_FLOOR, 0);
    send(mk(REQ_QUERY, 0, 0, 0, 0, 100, 200, 1));           // zero keep fraction
    wait_idle();

    // random phases, each with its own setting; the sender pacing varies between phases
    set_all(1, 16, 2, 40000, 8, 2, 3);
    run_phase(70, 1024);
    wait_idle();

    idle_pct = 73;
    set_all(1, 1, 0, 0, 64, 8, 1);
    run_phase(65, 64);
    wait_idle();

    idle_pct = 0;
    set_all(1, 256, 5, 20000, 5, 3, 2);
    run_phase(65, 16384);
    wait_idle();

    idle_pct = 25;
    set_all(1, 7, 4, 30000, 64, 1, 2);
    run_phase(65, 448);
    wait_idle();

    idle_pct = 0;
    set_all(0, 256, 64, 65536, 1, 8, 128);
    run_phase(15, 16384);
    wait_idle();

    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.flags_due.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
